// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    // Default grid size.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Character and attribute constants.
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
    localparam logic [7:0] TEXT_ATTR_RST  = 8'h0F;
    localparam logic [7:0] BLANK_ATTR_RST = 8'h07;

    // Register selects on the configuration port (address bit 2).
    localparam logic REG_TEXT_ATTR  = 1'b0;
    localparam logic REG_BLANK_ATTR = 1'b1;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_ERASE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Classified commands handed from the front to the back.
    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_ERASE,
        CMD_READ,
        CMD_READ_ZERO
    } t_cmd_kind;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL
    } t_back_state;

    typedef struct packed {
        t_op         op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        scrolled;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_cmd;

    typedef struct packed {
        logic [7:0] text_attr;
        logic [7:0] blank_attr;
    } t_cfg;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcw_queue.sv =====
module tcw_queue #(
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  tcw_pkg::t_cmd i_push_cmd,
    output logic         o_full,
    output logic         o_valid,
    output tcw_pkg::t_cmd o_cmd,
    input  logic         i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcw_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill-count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== rtl/tcw_front.sv =====
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tcw_pkg::t_in_item    i_in_item,
    input  tcw_pkg::t_back_status i_status,
    input  logic                 i_q_full,
    output logic                 o_push,
    output tcw_pkg::t_cmd         o_push_cmd
);

    localparam int CELL_COUNT = COLUMNS * ROWS;

    logic in_range;

    // Items are held off while the screen is cleared after reset and while the queue is full.
    assign o_in_ready = !i_status.init_busy && !i_q_full;
    assign o_push     = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_in_item.cell_index) < CELL_COUNT);

    // Classify the operation into a back-end command.
    always_comb begin
        o_push_cmd.char_code  = i_in_item.char_code;
        o_push_cmd.cell_index = i_in_item.cell_index;
        unique case (i_in_item.op)
            tcw_pkg::OP_PUT: begin
                o_push_cmd.kind = (i_in_item.char_code == tcw_pkg::NEWLINE_CHAR)
                                  ? tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_PUT;
            end
            tcw_pkg::OP_CLEAR: begin
                o_push_cmd.kind = tcw_pkg::CMD_CLEAR;
            end
            tcw_pkg::OP_ERASE: begin
                o_push_cmd.kind = tcw_pkg::CMD_ERASE;
            end
            tcw_pkg::OP_READ: begin
                o_push_cmd.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_READ_ZERO;
            end
            default: begin
                o_push_cmd.kind = tcw_pkg::CMD_READ_ZERO;
            end
        endcase
    end

endmodule

// ===== rtl/tcw_back.sv =====
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcw_pkg::t_cfg          i_cfg,
    input  logic                  i_cmd_valid,
    input  tcw_pkg::t_cmd          i_cmd,
    output logic                  o_pop,
    output tcw_pkg::t_back_status  o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tcw_pkg::t_out_item     o_out_item
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int SUM_W      = ADDR_W + 1;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [SUM_W-1:0]  CELLS_S    = SUM_W'(CELL_COUNT);
    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_SPAN_A = ADDR_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

    // Fold a sum of two in-range addresses back into the ring of cells.
    function automatic logic [ADDR_W-1:0] wrap_sum(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = (s >= CELLS_S) ? s - CELLS_S : s;
        return t[ADDR_W-1:0];
    endfunction

    tcw_pkg::t_back_state r_state, n_state;
    logic                 r_init, n_init;
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [ADDR_W-1:0]    r_cur_base, n_cur_base;
    logic [ADDR_W-1:0]    r_top_base, n_top_base;
    logic [ADDR_W-1:0]    r_fill_addr, n_fill_addr;
    logic [ADDR_W-1:0]    r_fill_end, n_fill_end;
    logic [15:0]          r_fill_data, n_fill_data;
    logic                 r_out_valid, n_out_valid;
    tcw_pkg::t_out_item   r_out_item, n_out_item;

    logic                 slot_free;
    logic [COL_W-1:0]     col_erase;
    logic [COL_W-1:0]     col_wr;
    logic [ADDR_W-1:0]    cursor_addr;
    logic [ADDR_W-1:0]    read_addr;
    logic [ADDR_W-1:0]    top_next;
    logic [15:0]          blank_cell;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [15:0]          ram_wdata;
    logic                 ram_re;
    logic [15:0]          ram_rdata;
    logic                 wrap_row;
    logic                 scroll;

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(CELL_COUNT)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(read_addr),
        .o_rdata(ram_rdata)
    );

    // Address arithmetic: row r of the screen sits r rows after the top row.
    assign slot_free   = !r_out_valid || i_out_ready;
    assign col_erase   = (r_col != '0) ? r_col - 1'b1 : r_col;
    assign col_wr      = (i_cmd.kind == tcw_pkg::CMD_ERASE) ? col_erase : r_col;
    assign cursor_addr = wrap_sum(SUM_W'(r_cur_base) + SUM_W'(col_wr) + SUM_W'(r_top_base));
    assign read_addr   = wrap_sum(SUM_W'(ADDR_W'(i_cmd.cell_index)) + SUM_W'(r_top_base));
    assign top_next    = wrap_sum(SUM_W'(r_top_base) + SUM_W'(COLS_A));
    assign blank_cell  = {i_cfg.blank_attr, tcw_pkg::SPACE_CHAR};

    assign o_status.init_busy = r_init;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out_item;

    // Command sequencer.
    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_col       = r_col;
        n_row       = r_row;
        n_cur_base  = r_cur_base;
        n_top_base  = r_top_base;
        n_fill_addr = r_fill_addr;
        n_fill_end  = r_fill_end;
        n_fill_data = r_fill_data;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cursor_addr;
        ram_wdata   = {i_cfg.text_attr, i_cmd.char_code};
        ram_re      = 1'b0;
        wrap_row    = 1'b0;
        scroll      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            tcw_pkg::ST_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        tcw_pkg::CMD_PUT: begin
                            ram_we   = 1'b1;
                            wrap_row = (r_col == LAST_COL);
                        end
                        tcw_pkg::CMD_NEWLINE: begin
                            wrap_row = 1'b1;
                        end
                        tcw_pkg::CMD_CLEAR: begin
                            n_col       = '0;
                            n_row       = '0;
                            n_cur_base  = '0;
                            n_top_base  = '0;
                            n_fill_addr = '0;
                            n_fill_end  = LAST_CELL;
                            n_fill_data = blank_cell;
                            n_state     = tcw_pkg::ST_FILL;
                        end
                        tcw_pkg::CMD_ERASE: begin
                            ram_we    = 1'b1;
                            ram_wdata = {i_cfg.text_attr, tcw_pkg::SPACE_CHAR};
                            n_col     = col_erase;
                        end
                        tcw_pkg::CMD_READ: begin
                            ram_re  = 1'b1;
                            n_state = tcw_pkg::ST_READ;
                        end
                        default: begin
                        end
                    endcase

                    // Cursor advance; past the last row the top row is recycled.
                    if ((i_cmd.kind == tcw_pkg::CMD_PUT) && !wrap_row) begin
                        n_col = r_col + 1'b1;
                    end else if (wrap_row) begin
                        n_col = '0;
                        if (r_row == LAST_ROW) begin
                            scroll      = 1'b1;
                            n_top_base  = top_next;
                            n_fill_addr = r_top_base;
                            n_fill_end  = r_top_base + ROW_SPAN_A;
                            n_fill_data = blank_cell;
                            n_state     = tcw_pkg::ST_FILL;
                        end else begin
                            n_row      = r_row + 1'b1;
                            n_cur_base = r_cur_base + COLS_A;
                        end
                    end

                    if (i_cmd.kind != tcw_pkg::CMD_READ) begin
                        n_out_valid            = 1'b1;
                        n_out_item.cell_value  = '0;
                        n_out_item.cursor_col  = 7'(n_col);
                        n_out_item.cursor_row  = 5'(n_row);
                        n_out_item.scrolled    = scroll;
                    end
                end
            end
            tcw_pkg::ST_READ: begin
                n_out_valid           = 1'b1;
                n_out_item.cell_value = ram_rdata;
                n_out_item.cursor_col = 7'(r_col);
                n_out_item.cursor_row = 5'(r_row);
                n_out_item.scrolled   = 1'b0;
                n_state               = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_fill_addr;
                ram_wdata = r_fill_data;
                if (r_fill_addr == r_fill_end) begin
                    n_init  = 1'b0;
                    n_state = tcw_pkg::ST_IDLE;
                end else begin
                    n_fill_addr = r_fill_addr + 1'b1;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Reset starts a fill pass over the whole screen.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_FILL;
            r_init      <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_cur_base  <= '0;
            r_top_base  <= '0;
            r_fill_addr <= '0;
            r_fill_end  <= LAST_CELL;
            r_fill_data <= {tcw_pkg::BLANK_ATTR_RST, tcw_pkg::SPACE_CHAR};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_col       <= n_col;
            r_row       <= n_row;
            r_cur_base  <= n_cur_base;
            r_top_base  <= n_top_base;
            r_fill_addr <= n_fill_addr;
            r_fill_end  <= n_fill_end;
            r_fill_data <= n_fill_data;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// Text console writer: a COLUMNS by ROWS grid of 16-bit cells (attribute in the
// high byte, character in the low byte) with a cursor.
// Input channel (i_in_valid / o_in_ready, i_in_item) takes put, clear,
// erase-back and read items; the output channel (o_out_valid / i_out_ready,
// o_out_item) returns exactly one result item per input item, in order.
// The text and blank attributes are written over the APB port at 0x0 and 0x4.
// A front end classifies items into a two-entry command queue; the back end
// executes them against a cell memory with one write port and one registered
// read port, organized as a ring of rows. Results pass through the command
// queue and the output register; an in-range read also passes through the
// registered memory read and the read state. The back end takes an item only
// while idle with the output register free; it is busy in the read state after
// a read, and blanks the recycled row after a scroll or the grid after a clear.
// After reset the grid is blanked in a fill pass over all COLUMNS*ROWS cells
// (2000 at the default size), during which no item is accepted; configuration
// writes are taken at any time. If the receiver stalls, one result waits in the
// output register and the queue keeps accepting items until it is full.
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcw_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcw_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0]            r_text_attr;
    logic [7:0]            r_blank_attr;
    logic                  cfg_write;
    tcw_pkg::t_cfg          cfg;
    tcw_pkg::t_back_status  status;
    logic                  push;
    tcw_pkg::t_cmd          push_cmd;
    logic                  q_full;
    logic                  q_valid;
    tcw_pkg::t_cmd          q_cmd;
    logic                  pop;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr  <= tcw_pkg::TEXT_ATTR_RST;
            r_blank_attr <= tcw_pkg::BLANK_ATTR_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                tcw_pkg::REG_TEXT_ATTR:  r_text_attr  <= pwdata[7:0];
                tcw_pkg::REG_BLANK_ATTR: r_blank_attr <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            tcw_pkg::REG_TEXT_ATTR:  prdata = {24'd0, r_text_attr};
            tcw_pkg::REG_BLANK_ATTR: prdata = {24'd0, r_blank_attr};
            default:                 prdata = '0;
        endcase
    end

    assign cfg.text_attr  = r_text_attr;
    assign cfg.blank_attr = r_blank_attr;

    tcw_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item (i_in_item),
        .i_status  (status),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_push_cmd(push_cmd)
    );

    tcw_queue #(
        .DEPTH(tcw_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_cmd(push_cmd),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_cmd     (q_cmd),
        .i_pop     (pop)
    );

    tcw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd_valid(q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

// ===== sim/text_console_writer_unit_test.sv =====
`timescale 1ns / 1ps

module text_console_writer_unit_test;

    localparam int COLS  = tcw_pkg::DEF_COLUMNS;
    localparam int LINES = tcw_pkg::DEF_ROWS;
    localparam int CELLS = COLS * LINES;

    // Clock, reset and the ports of the block.
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    tcw_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    tcw_pkg::t_out_item o_out_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the console: grid, cursor and attributes.
    logic [15:0] grid [CELLS];
    int          cur_col;
    int          cur_row;
    logic [7:0]  txt_attr;
    logic [7:0]  blk_attr;

    // Status items predicted for accepted commands, oldest first.
    tcw_pkg::t_out_item predicted_status [$];
    int          mismatch_count = 0;
    bit          bursts_on = 1'b1;
    int          ready_hold = 0;

    text_console_writer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one command to the mirror and returns the status it produces.
    function automatic tcw_pkg::t_out_item console_apply(tcw_pkg::t_in_item cmd);
        tcw_pkg::t_out_item res;
        int                 i;
        res = '0;
        case (cmd.op)
            tcw_pkg::OP_PUT: begin
                if (cmd.char_code == tcw_pkg::NEWLINE_CHAR) begin
                    cur_col = 0;
                    cur_row++;
                end else begin
                    grid[cur_row * COLS + cur_col] = {txt_attr, cmd.char_code};
                    cur_col++;
                end
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // Falling off the bottom scrolls everything up one row.
                if (cur_row >= LINES) begin
                    for (i = 0; i < (LINES - 1) * COLS; i++) grid[i] = grid[i + COLS];
                    for (i = (LINES - 1) * COLS; i < CELLS; i++)
                        grid[i] = {blk_attr, tcw_pkg::SPACE_CHAR};
                    cur_row = LINES - 1;
                    res.scrolled = 1'b1;
                end
            end
            tcw_pkg::OP_CLEAR: begin
                for (i = 0; i < CELLS; i++) grid[i] = {blk_attr, tcw_pkg::SPACE_CHAR};
                cur_col = 0;
                cur_row = 0;
            end
            tcw_pkg::OP_ERASE: begin
                if (cur_col > 0) cur_col--;
                grid[cur_row * COLS + cur_col] = {txt_attr, tcw_pkg::SPACE_CHAR};
            end
            default: begin
                if (cmd.cell_index < CELLS) res.cell_value = grid[cmd.cell_index];
            end
        endcase
        res.cursor_col = 7'(cur_col);
        res.cursor_row = 5'(cur_row);
        return res;
    endfunction

    // Sends one command item, with an optional idle burst ahead of it.
    task automatic send_cmd(tcw_pkg::t_op op, logic [7:0] ch, logic [10:0] idx);
        tcw_pkg::t_in_item cmd;
        int                gap;
        cmd.op         = op;
        cmd.char_code  = ch;
        cmd.cell_index = idx;
        @(negedge i_clk);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = cmd;
        do @(posedge i_clk); while (!o_in_ready);
        predicted_status.push_back(console_apply(cmd));
    endtask

    // Drops valid and waits until every predicted status has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (predicted_status.size() != 0) @(posedge i_clk);
    endtask

    // Writes one attribute register; the grid must be idle.
    task automatic write_attr(logic sel, logic [7:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = {24'h0, val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == tcw_pkg::REG_TEXT_ATTR) txt_attr = val;
        else blk_attr = val;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Mostly lines of text ending in a newline, mixed with reads, erases, clears and noise.
    task automatic run_traffic(int count);
        int sent;
        int len;
        int k;
        int pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                                  : $urandom_range(0, 40);
                for (k = 0; k < len && sent < count; k++) begin
                    send_cmd(tcw_pkg::OP_PUT, 8'($urandom_range(32, 126)), 11'($urandom));
                    sent++;
                end
                if (sent < count && $urandom_range(0, 4) != 0) begin
                    send_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CHAR, 11'($urandom));
                    sent++;
                end
            end else begin
                if (pick < 70) begin
                    send_cmd(tcw_pkg::OP_READ, 8'($urandom),
                             11'(cur_row * COLS + $urandom_range(0, COLS - 1)));
                end else if (pick < 80) begin
                    send_cmd(tcw_pkg::OP_READ, 8'($urandom), 11'($urandom));
                end else if (pick < 90) begin
                    send_cmd(tcw_pkg::OP_ERASE, 8'($urandom), 11'($urandom));
                end else if (pick < 99) begin
                    send_cmd(tcw_pkg::t_op'($urandom_range(0, 3)), 8'($urandom),
                             11'($urandom));
                end else begin
                    send_cmd(tcw_pkg::OP_CLEAR, 8'($urandom), 11'($urandom));
                end
                sent++;
            end
        end
    endtask

    // Reads of the blank grid after reset, including past the last cell.
    task automatic test_reset_contents();
        send_cmd(tcw_pkg::OP_READ, 8'h00, 11'd0);
        send_cmd(tcw_pkg::OP_READ, 8'hFF, 11'(CELLS - 1));
        send_cmd(tcw_pkg::OP_READ, 8'h00, 11'(CELLS));
        send_cmd(tcw_pkg::OP_READ, 8'hFF, 11'h7FF);
    endtask

    // Character extremes, newline, and erase-back at and away from column 0.
    task automatic test_put_and_erase();
        send_cmd(tcw_pkg::OP_ERASE, 8'h00, 11'd0);
        send_cmd(tcw_pkg::OP_PUT, 8'h00, 11'h7FF);
        send_cmd(tcw_pkg::OP_PUT, 8'hFF, 11'd0);
        send_cmd(tcw_pkg::OP_PUT, 8'h41, 11'd0);
        send_cmd(tcw_pkg::OP_READ, 8'h00, 11'd1);
        send_cmd(tcw_pkg::OP_READ, 8'h00, 11'd2);
        send_cmd(tcw_pkg::OP_ERASE, 8'h00, 11'd0);
        send_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CHAR, 11'd0);
        send_cmd(tcw_pkg::OP_ERASE, 8'h00, 11'd0);
        send_cmd(tcw_pkg::OP_READ, 8'h00, 11'(COLS));
        send_cmd(tcw_pkg::OP_READ, 8'h00, 11'd2);
    endtask

    // Clear blanks the grid and homes the cursor.
    task automatic test_clear();
        send_cmd(tcw_pkg::OP_PUT, 8'h58, 11'd0);
        send_cmd(tcw_pkg::OP_CLEAR, 8'h00, 11'd0);
        send_cmd(tcw_pkg::OP_READ, 8'h00, 11'd0);
        send_cmd(tcw_pkg::OP_READ, 8'h00, 11'(COLS));
    endtask

    // Traffic under several attribute settings, extremes included.
    task automatic test_attribute_settings();
        logic [7:0] text_set  [5];
        logic [7:0] blank_set [5];
        int         p;
        text_set  = '{8'h00, 8'hFF, 8'h5A, 8'($urandom), tcw_pkg::TEXT_ATTR_RST};
        blank_set = '{8'hFF, 8'h00, 8'hA5, 8'($urandom), tcw_pkg::BLANK_ATTR_RST};
        for (p = 0; p < 5; p++) begin
            // Let any grid fill that outlives its status item finish first.
            wait_for_results();
            repeat (CELLS + 100) @(posedge i_clk);
            write_attr(tcw_pkg::REG_TEXT_ATTR, text_set[p]);
            write_attr(tcw_pkg::REG_BLANK_ATTR, blank_set[p]);
            run_traffic(250);
        end
    endtask

    // The sender holds off until the block has answered everything.
    task automatic test_back_pressure_pause();
        run_traffic(100);
        wait_for_results();
        run_traffic(100);
    endtask

    // Both sides run without idle bursts.
    task automatic test_full_rate();
        bursts_on = 1'b0;
        run_traffic(250);
    endtask

    // Receiver side: random stall bursts on ready.
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold  = ready_hold - 1;
            i_out_ready = 1'b0;
        end else if (bursts_on && $urandom_range(0, 9) == 0) begin
            ready_hold  = $urandom_range(1, 19) - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // Each status item is compared with the oldest prediction.
    always @(posedge i_clk) begin
        tcw_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_status.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected status item %h", o_out_item);
            end else begin
                want = predicted_status.pop_front();
                if (o_out_item.cell_value !== want.cell_value
                        || o_out_item.cursor_col !== want.cursor_col
                        || o_out_item.cursor_row !== want.cursor_row
                        || o_out_item.scrolled !== want.scrolled) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("status mismatch: expected cell %h col %0d row %0d scr %0d, ",
                               want.cell_value, want.cursor_col, want.cursor_row,
                               want.scrolled);
                        $display("got cell %h col %0d row %0d scr %0d",
                                 o_out_item.cell_value, o_out_item.cursor_col,
                                 o_out_item.cursor_row, o_out_item.scrolled);
                    end
                end
            end
        end
    end

    // Main sequence.
    initial begin
        int i;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        txt_attr   = tcw_pkg::TEXT_ATTR_RST;
        blk_attr   = tcw_pkg::BLANK_ATTR_RST;
        cur_col    = 0;
        cur_row    = 0;
        for (i = 0; i < CELLS; i++) grid[i] = {tcw_pkg::BLANK_ATTR_RST, tcw_pkg::SPACE_CHAR};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_contents();
        test_put_and_erase();
        test_clear();
        test_attribute_settings();
        test_back_pressure_pause();
        test_full_rate();

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_status.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
